### rtl/time_of_day_counter_macros.svh
// Assertion macros used by the time-of-day counter back end.
`ifndef TIME_OF_DAY_COUNTER_MACROS_SVH
`define TIME_OF_DAY_COUNTER_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define TDC_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// Trigger in one cycle implies the condition in the next.
`define TDC_ASSERT_NEXT(label, clk, rstn, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (cond)) \
        else $error(msg);

`endif

### rtl/tdc_pkg.sv
// Shared constants, codes and types of the time-of-day counter.
`default_nettype none

package tdc_pkg;

    localparam int unsigned HOUR_W = 5;
    localparam int unsigned MIN_W = 6;
    localparam int unsigned SEC_W = 6;
    localparam int unsigned TOD_W = 17;
    localparam int unsigned CMD_W = 3;
    localparam int unsigned FIELD_W = 32;

    localparam int unsigned S_TDATA_W = 4 * FIELD_W;
    localparam int unsigned M_TDATA_W = 40;

    localparam int unsigned SECS_PER_HOUR = 3600;
    localparam int unsigned SECS_PER_MIN = 60;
    localparam int unsigned HOURS_PER_DAY = 24;
    localparam int unsigned SECS_PER_DAY = SECS_PER_HOUR * HOURS_PER_DAY;
    localparam int unsigned LAST_SEC = 59;
    localparam int unsigned LAST_MIN = 59;
    localparam int unsigned LAST_HOUR = 23;

    // Reciprocals for constant division; each estimate is low by at most one.
    localparam int unsigned DAY_SHIFT = 48;
    localparam logic [31:0] DAY_RECIP = 32'((64'd1 << DAY_SHIFT) / 64'(SECS_PER_DAY));
    localparam int unsigned HOUR_SHIFT = 27;
    localparam logic [15:0] HOUR_RECIP = 16'((64'd1 << HOUR_SHIFT) / 64'(SECS_PER_HOUR));
    localparam int unsigned MIN_SHIFT = 16;
    localparam logic [10:0] MIN_RECIP = 11'((64'd1 << MIN_SHIFT) / 64'(SECS_PER_MIN));

    localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK_UP      = 3'd0,
        CMD_TICK_DOWN    = 3'd1,
        CMD_LOAD_HMS     = 3'd2,
        CMD_LOAD_SECONDS = 3'd3,
        CMD_ADD_SECONDS  = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_TICK_UP,
        OP_TICK_DOWN,
        OP_LOAD,
        OP_ADD
    } op_kind_t;

    typedef struct packed {
        op_kind_t          kind;
        logic [HOUR_W-1:0] hh;
        logic [MIN_W-1:0]  mm;
        logic [SEC_W-1:0]  ss;
        logic [TOD_W-1:0]  total;
    } op_t;

endpackage

`default_nettype wire

### rtl/tdc_front.sv
// Command front end: classify commands and split second counts into h:m:s.
`default_nettype none

module tdc_front (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [tdc_pkg::CMD_W-1:0]   in_cmd,
    input  wire logic [tdc_pkg::FIELD_W-1:0] in_hour,
    input  wire logic [tdc_pkg::FIELD_W-1:0] in_minute,
    input  wire logic [tdc_pkg::FIELD_W-1:0] in_second,
    input  wire logic [tdc_pkg::FIELD_W-1:0] in_value,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output tdc_pkg::op_t                     out_op
);
    import tdc_pkg::*;

    localparam int unsigned STAGES = 7;
    localparam int unsigned NUM_W = FIELD_W - 1;
    localparam int unsigned PROD_W = NUM_W + 32;
    localparam int unsigned REM_W = 12;

    typedef enum logic [1:0] {
        SRC_ZERO,
        SRC_HMS,
        SRC_SPLIT
    } src_t;

    typedef struct packed {
        op_kind_t          kind;
        src_t              src;
        logic [HOUR_W-1:0] hh;
        logic [MIN_W-1:0]  mm;
        logic [SEC_W-1:0]  ss;
        logic [TOD_W-1:0]  total;
    } side_t;

    logic              en;
    logic [STAGES-1:0] valid_reg;
    side_t             side_reg [STAGES];
    side_t             side_next;
    logic              hms_ok;
    cmd_t              cmd;

    logic [PROD_W-1:0] prod1_reg, prod1_next;
    logic [NUM_W-1:0]  num1_reg, num2_reg;
    logic [31:0]       qd2_reg, qd2_next;
    logic [31:0]       diff3;
    logic [TOD_W-1:0]  r3_reg, r3_next, r4_reg, r5_reg, r6_reg, r7_reg;
    logic [31:0]       hprod4;
    logic [HOUR_W-1:0] hest4_reg, h5_reg, h5_next, h6_reg, h7_reg;
    logic [TOD_W-1:0]  hrem5;
    logic [REM_W-1:0]  rem5_reg, rem5_next, rem6_reg;
    logic [21:0]       mprod6;
    logic [MIN_W-1:0]  mest6_reg, m7_next, m7_reg;
    logic [REM_W-1:0]  srem7;
    logic [SEC_W-1:0]  s7_next, s7_reg;

    assign en        = !valid_reg[STAGES-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = valid_reg[STAGES-1];
    assign cmd       = cmd_t'(in_cmd);

    assign hms_ok = (in_hour <= FIELD_W'(LAST_HOUR)) && (in_minute <= FIELD_W'(LAST_MIN))
                    && (in_second <= FIELD_W'(LAST_SEC));

    always_comb begin
        side_next.hh    = hms_ok ? in_hour[HOUR_W-1:0] : '0;
        side_next.mm    = hms_ok ? in_minute[MIN_W-1:0] : '0;
        side_next.ss    = hms_ok ? in_second[SEC_W-1:0] : '0;
        side_next.total = TOD_W'(side_next.hh * SECS_PER_HOUR + side_next.mm * SECS_PER_MIN
                                 + side_next.ss);
        unique case (cmd)
            CMD_TICK_UP: begin
                side_next.kind = OP_TICK_UP;
                side_next.src  = SRC_ZERO;
            end
            CMD_TICK_DOWN: begin
                side_next.kind = OP_TICK_DOWN;
                side_next.src  = SRC_ZERO;
            end
            CMD_LOAD_HMS: begin
                side_next.kind = OP_LOAD;
                side_next.src  = SRC_HMS;
            end
            CMD_LOAD_SECONDS: begin
                side_next.kind = OP_LOAD;
                side_next.src  = in_value[FIELD_W-1] ? SRC_ZERO : SRC_SPLIT;
            end
            CMD_ADD_SECONDS: begin
                side_next.kind = in_value[FIELD_W-1] ? OP_HOLD : OP_ADD;
                side_next.src  = SRC_SPLIT;
            end
            default: begin
                side_next.kind = OP_HOLD;
                side_next.src  = SRC_ZERO;
            end
        endcase
    end

    // Day quotient estimate, remainder, then hours, minutes and seconds.
    assign prod1_next = PROD_W'(in_value[NUM_W-1:0]) * PROD_W'(DAY_RECIP);
    assign qd2_next   = 32'(prod1_reg[PROD_W-1:DAY_SHIFT]) * 32'(SECS_PER_DAY);
    assign diff3      = 32'(num2_reg) - qd2_reg;
    assign r3_next    = TOD_W'((diff3 >= SECS_PER_DAY) ? diff3 - SECS_PER_DAY : diff3);
    assign hprod4     = 32'(r3_reg) * 32'(HOUR_RECIP);
    assign hrem5      = r4_reg - TOD_W'(hest4_reg * SECS_PER_HOUR);

    always_comb begin
        if (hrem5 >= SECS_PER_HOUR) begin
            rem5_next = REM_W'(hrem5 - SECS_PER_HOUR);
            h5_next   = hest4_reg + 1'b1;
        end else begin
            rem5_next = REM_W'(hrem5);
            h5_next   = hest4_reg;
        end
    end

    assign mprod6 = 22'(rem5_reg) * 22'(MIN_RECIP);
    assign srem7  = rem6_reg - REM_W'(mest6_reg * SECS_PER_MIN);

    always_comb begin
        if (srem7 >= SECS_PER_MIN) begin
            s7_next = SEC_W'(srem7 - SECS_PER_MIN);
            m7_next = mest6_reg + 1'b1;
        end else begin
            s7_next = SEC_W'(srem7);
            m7_next = mest6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_next;
            for (int i = 1; i < STAGES; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
            prod1_reg <= prod1_next;
            num1_reg  <= in_value[NUM_W-1:0];
            qd2_reg   <= qd2_next;
            num2_reg  <= num1_reg;
            r3_reg    <= r3_next;
            hest4_reg <= hprod4[HOUR_SHIFT+HOUR_W-1:HOUR_SHIFT];
            r4_reg    <= r3_reg;
            h5_reg    <= h5_next;
            rem5_reg  <= rem5_next;
            r5_reg    <= r4_reg;
            mest6_reg <= mprod6[MIN_SHIFT+MIN_W-1:MIN_SHIFT];
            h6_reg    <= h5_reg;
            rem6_reg  <= rem5_reg;
            r6_reg    <= r5_reg;
            h7_reg    <= h6_reg;
            m7_reg    <= m7_next;
            s7_reg    <= s7_next;
            r7_reg    <= r6_reg;
        end
    end

    always_comb begin
        out_op.kind = side_reg[STAGES-1].kind;
        unique case (side_reg[STAGES-1].src)
            SRC_HMS: begin
                out_op.hh    = side_reg[STAGES-1].hh;
                out_op.mm    = side_reg[STAGES-1].mm;
                out_op.ss    = side_reg[STAGES-1].ss;
                out_op.total = side_reg[STAGES-1].total;
            end
            SRC_SPLIT: begin
                out_op.hh    = h7_reg;
                out_op.mm    = m7_reg;
                out_op.ss    = s7_reg;
                out_op.total = r7_reg;
            end
            default: begin
                out_op.hh    = '0;
                out_op.mm    = '0;
                out_op.ss    = '0;
                out_op.total = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/tdc_queue.sv
// Short FIFO of classified operations between front end and back end.
`default_nettype none

module tdc_queue #(
    parameter int unsigned DEPTH = tdc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire tdc_pkg::op_t in_op,
    output logic              out_valid,
    input  wire logic         out_ready,
    output tdc_pkg::op_t      out_op
);
    import tdc_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    op_t              mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = count_reg != CNT_W'(DEPTH);
    assign out_valid = count_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_op    = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_op;
        end
    end

endmodule

`default_nettype wire

### rtl/tdc_back.sv
// Time-of-day state and result register: apply one operation per cycle while out_ready does not hold the result.
`default_nettype none
`include "time_of_day_counter_macros.svh"

module tdc_back (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       op_valid,
    output logic                            op_ready,
    input  wire tdc_pkg::op_t               op,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [tdc_pkg::HOUR_W-1:0]      out_hour,
    output logic [tdc_pkg::MIN_W-1:0]       out_minute,
    output logic [tdc_pkg::SEC_W-1:0]       out_second,
    output logic [tdc_pkg::TOD_W-1:0]       out_total
);
    import tdc_pkg::*;

    logic [HOUR_W-1:0] hour_reg, hour_next, out_hour_reg;
    logic [MIN_W-1:0]  minute_reg, minute_next, out_minute_reg;
    logic [SEC_W-1:0]  second_reg, second_next, out_second_reg;
    logic [TOD_W-1:0]  total_reg, total_next, out_total_reg;
    logic              out_valid_reg;
    logic              pop;

    logic [SEC_W:0]    sec_sum;
    logic              sec_carry;
    logic [MIN_W:0]    min_sum;
    logic              min_carry;
    logic [HOUR_W:0]   hour_sum;
    logic [TOD_W:0]    tot_sum;

    assign op_ready = !out_valid_reg || out_ready;
    assign pop      = op_valid && op_ready;

    // Mixed-radix add of the day offset, with a carry from seconds into minutes and from minutes into hours.
    assign sec_sum   = (SEC_W + 1)'(second_reg) + (SEC_W + 1)'(op.ss);
    assign sec_carry = sec_sum >= SECS_PER_MIN;
    assign min_sum   = (MIN_W + 1)'(minute_reg) + (MIN_W + 1)'(op.mm) + (MIN_W + 1)'(sec_carry);
    assign min_carry = min_sum >= SECS_PER_MIN;
    assign hour_sum  = (HOUR_W + 1)'(hour_reg) + (HOUR_W + 1)'(op.hh) + (HOUR_W + 1)'(min_carry);
    assign tot_sum   = (TOD_W + 1)'(total_reg) + (TOD_W + 1)'(op.total);

    always_comb begin
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        total_next  = total_reg;
        if (pop) begin
            unique case (op.kind)
                OP_TICK_UP: begin
                    total_next = (total_reg == TOD_W'(SECS_PER_DAY - 1)) ? '0 : total_reg + 1'b1;
                    if (second_reg != SEC_W'(LAST_SEC)) begin
                        second_next = second_reg + 1'b1;
                    end else begin
                        second_next = '0;
                        if (minute_reg != MIN_W'(LAST_MIN)) begin
                            minute_next = minute_reg + 1'b1;
                        end else begin
                            minute_next = '0;
                            hour_next   = (hour_reg == HOUR_W'(LAST_HOUR)) ? '0
                                                                           : hour_reg + 1'b1;
                        end
                    end
                end
                OP_TICK_DOWN: begin
                    total_next = (total_reg == '0) ? TOD_W'(SECS_PER_DAY - 1) : total_reg - 1'b1;
                    if (second_reg != '0) begin
                        second_next = second_reg - 1'b1;
                    end else begin
                        second_next = SEC_W'(LAST_SEC);
                        if (minute_reg != '0) begin
                            minute_next = minute_reg - 1'b1;
                        end else begin
                            minute_next = MIN_W'(LAST_MIN);
                            hour_next   = (hour_reg == '0) ? HOUR_W'(LAST_HOUR)
                                                           : hour_reg - 1'b1;
                        end
                    end
                end
                OP_LOAD: begin
                    hour_next   = op.hh;
                    minute_next = op.mm;
                    second_next = op.ss;
                    total_next  = op.total;
                end
                OP_ADD: begin
                    second_next = SEC_W'(sec_carry ? sec_sum - SECS_PER_MIN : 32'(sec_sum));
                    minute_next = MIN_W'(min_carry ? min_sum - SECS_PER_MIN : 32'(min_sum));
                    hour_next   = HOUR_W'((hour_sum >= HOURS_PER_DAY) ? hour_sum - HOURS_PER_DAY
                                                                      : 32'(hour_sum));
                    total_next  = TOD_W'((tot_sum >= SECS_PER_DAY) ? tot_sum - SECS_PER_DAY
                                                                   : 32'(tot_sum));
                end
                default: begin
                    hour_next = hour_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hour_reg      <= '0;
            minute_reg    <= '0;
            second_reg    <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            hour_reg   <= hour_next;
            minute_reg <= minute_next;
            second_reg <= second_next;
            total_reg  <= total_next;
            if (pop) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_hour_reg   <= hour_next;
            out_minute_reg <= minute_next;
            out_second_reg <= second_next;
            out_total_reg  <= total_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_hour   = out_hour_reg;
    assign out_minute = out_minute_reg;
    assign out_second = out_second_reg;
    assign out_total  = out_total_reg;

    `TDC_ASSERT_ALWAYS(a_state_range, aclk, aresetn, (hour_reg <= HOUR_W'(LAST_HOUR)) && (minute_reg <= MIN_W'(LAST_MIN)) && (second_reg <= SEC_W'(LAST_SEC)), "time of day out of range")
    `TDC_ASSERT_ALWAYS(a_total_matches, aclk, aresetn, total_reg == TOD_W'(hour_reg * SECS_PER_HOUR + minute_reg * SECS_PER_MIN + second_reg), "seconds-of-day total disagrees with h:m:s")
    `TDC_ASSERT_NEXT(a_result_tracks_state, aclk, aresetn, pop, out_valid_reg && (out_total_reg == total_reg) && (out_hour_reg == hour_reg) && (out_second_reg == second_reg), "result register does not match state")

endmodule

`default_nettype wire

### rtl/time_of_day_counter.sv
// Top level of the 24-hour hh:mm:ss time-of-day counter.
// Takes one command per cycle on the s_ stream while s_tready is high and returns exactly one
// result per command on the m_ stream, in order: the time after the command and its
// seconds-of-day total. A command passes a seven-stage front end that classifies it and
// splits any second count into h:m:s with reciprocal multiplies, waits in a QUEUE_DEPTH-entry
// FIFO, and is applied by the back end, whose update of the time registers sets the sustained
// rate of one command per clock while m_tready stays high. Back pressure on m_tready stalls
// the back end first; the FIFO then fills and the front end holds until space opens.
`default_nettype none

module time_of_day_counter #(
    parameter int unsigned QUEUE_DEPTH = tdc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // hour_in [31:0], minute_in [63:32], second_in [95:64], seconds_value [127:96]
    input  wire logic [tdc_pkg::S_TDATA_W-1:0] s_tdata,
    // command [2:0]
    input  wire logic [tdc_pkg::CMD_W-1:0]     s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // hour_out [4:0], minute_out [10:5], second_out [16:11], seconds_of_day [33:17], zero pad
    output logic [tdc_pkg::M_TDATA_W-1:0]      m_tdata
);
    import tdc_pkg::*;

    localparam int unsigned PAD_W = M_TDATA_W - (HOUR_W + MIN_W + SEC_W + TOD_W);

    logic              fq_valid, fq_ready;
    op_t               fq_op;
    logic              qb_valid, qb_ready;
    op_t               qb_op;
    logic [HOUR_W-1:0] res_hour;
    logic [MIN_W-1:0]  res_minute;
    logic [SEC_W-1:0]  res_second;
    logic [TOD_W-1:0]  res_total;

    tdc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tuser),
        .in_hour   (s_tdata[FIELD_W-1:0]),
        .in_minute (s_tdata[2*FIELD_W-1:FIELD_W]),
        .in_second (s_tdata[3*FIELD_W-1:2*FIELD_W]),
        .in_value  (s_tdata[4*FIELD_W-1:3*FIELD_W]),
        .out_valid (fq_valid),
        .out_ready (fq_ready),
        .out_op    (fq_op)
    );

    tdc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_op     (fq_op),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_op    (qb_op)
    );

    tdc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .op_valid   (qb_valid),
        .op_ready   (qb_ready),
        .op         (qb_op),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_hour   (res_hour),
        .out_minute (res_minute),
        .out_second (res_second),
        .out_total  (res_total)
    );

    assign m_tdata = {PAD_W'(0), res_total, res_second, res_minute, res_hour};

endmodule

`default_nettype wire
